// ===== rtl/ugsi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ugsi_pkg;

    // request codes
    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;

    // configuration register indexes
    localparam int         CFG_AW       = 2;
    localparam logic [1:0] CFG_GRID_DIV = 2'd0;
    localparam logic [1:0] CFG_SCENE_W  = 2'd1;
    localparam logic [1:0] CFG_SCENE_H  = 2'd2;

    localparam int CFG_DW  = 16;
    localparam int DIV_W   = 5;
    localparam int SCENE_W = 16;
    localparam int CNT_W   = 9;
    localparam int MASK_W  = 64;
    localparam int ID_W    = 6;

    localparam logic [DIV_W-1:0]   GRID_DIV_RST = 5'd1;
    localparam logic [SCENE_W-1:0] SCENE_RST    = 16'd256;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_SETUP,
        ST_WALK,
        ST_DRAIN
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/uniform_grid_spatial_index.sv =====
`timescale 1ns / 1ps
`default_nettype none

// flow: a start transfer taken in idle runs the multiply, divide and setup states, walks the covered
//   cells and drains before the result strobe; an inverted box or an out of range entity ends at setup
// throughput: a new request is taken only back in idle; one cell memory read-modify-write per
//   cycle during the walk, plus the bit-serial cell index divider (one quotient bit per cycle)
// reset: synchronous, clears registers then sweeps all GRID_MAX*GRID_MAX cells to zero with busy
//   high; the receiver cannot stall, each result shows for one cycle

module uniform_grid_spatial_index
    import ugsi_pkg::*;
#(
    parameter int MAX_ENTITIES = 64,
    parameter int GRID_MAX     = 16,
    parameter int COORD_BITS   = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [CFG_AW-1:0]            i_cfg_addr,
    input  wire logic [CFG_DW-1:0]            i_cfg_wdata,
    input  wire logic                         i_start,
    output logic                              o_busy,
    input  wire logic [1:0]                   i_req_type,
    input  wire logic [ID_W-1:0]              i_entity_id,
    input  wire logic signed [COORD_BITS-1:0] i_box_x_min,
    input  wire logic signed [COORD_BITS-1:0] i_box_y_min,
    input  wire logic signed [COORD_BITS-1:0] i_box_x_max,
    input  wire logic signed [COORD_BITS-1:0] i_box_y_max,
    output logic                              o_done,
    output logic [MASK_W-1:0]                 o_neighbour_mask,
    output logic [CNT_W-1:0]                  o_cells_covered
);

    localparam int CW    = COORD_BITS;
    localparam int ME    = MAX_ENTITIES;
    localparam int DEPTH = GRID_MAX * GRID_MAX;
    localparam int AW    = $clog2(DEPTH);
    localparam int QW    = $clog2(GRID_MAX);
    localparam int KW    = (QW > 1) ? $clog2(QW) : 1;
    localparam int DW    = $clog2(GRID_MAX + 1);
    localparam int PW    = ((CW > SCENE_W) ? CW + 1 : SCENE_W + 1) + 1;
    localparam int NW    = PW + DW + 1;
    localparam int LW    = SCENE_W + 1 + DW;
    localparam int SW_PAD = SCENE_W;

    t_state r_state, n_state;

    logic [DIV_W-1:0]   r_grid_div;
    logic [SCENE_W-1:0] r_scene_w, r_scene_h;

    logic [1:0]           r_req;
    logic [ID_W-1:0]      r_id;
    logic signed [CW-1:0] r_coord [4];

    logic [NW-1:0]      r_num [4];
    logic [NW-1:0]      r_rem [4];
    logic [QW-1:0]      r_q   [4];
    logic [LW-1:0]      r_lim [2];
    logic [SCENE_W:0]   r_s2  [2];
    logic [KW-1:0]      r_k;

    logic [QW-1:0]  r_x0, r_x1, r_y1, r_cx, r_cy;
    logic [CNT_W-1:0] r_cnt;
    logic [ME-1:0]  r_acc;
    logic           r_rd_vld;
    logic [AW-1:0]  r_rd_addr;
    logic [AW-1:0]  r_clr;

    logic             r_done;
    logic [MASK_W-1:0] r_mask;
    logic [CNT_W-1:0] r_count;

    logic [DW-1:0]      w_d;
    logic [SCENE_W-1:0] w_sw, w_sh;
    logic [QW-1:0]      w_cell [4];
    logic               w_early;
    logic               w_last;
    logic [ME-1:0]      w_bit;
    logic [ME-1:0]      w_rdata;
    logic               w_we;
    logic [AW-1:0]      w_waddr, w_raddr;
    logic [ME-1:0]      w_wdata;

    // effective divisions and scene sizes
    always_comb begin
        if (r_grid_div == '0) begin
            w_d = DW'(1);
        end else if (int'(r_grid_div) > GRID_MAX) begin
            w_d = DW'(GRID_MAX);
        end else begin
            w_d = DW'(r_grid_div);
        end
        w_sw = (r_scene_w == '0) ? SCENE_W'(1) : r_scene_w;
        w_sh = (r_scene_h == '0) ? SCENE_W'(1) : r_scene_h;
    end

    // final cell indices: below the scene gives zero, beyond it the last cell
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (r_num[i][NW-1]) begin
                w_cell[i] = '0;
            end else if (r_num[i] >= NW'(r_lim[i % 2])) begin
                w_cell[i] = QW'(w_d - DW'(1));
            end else begin
                w_cell[i] = r_q[i];
            end
        end
        w_early = (int'(r_id) >= ME) || (w_cell[0] > w_cell[2]) || (w_cell[1] > w_cell[3]);
    end

    assign w_last  = (r_cx == r_x1) && (r_cy == r_y1);
    assign w_bit   = ME'(1) << r_id;
    assign w_raddr = AW'(r_cy) * AW'(GRID_MAX) + AW'(r_cx);
    assign o_busy  = (r_state != ST_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr == AW'(DEPTH - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (i_start) n_state = ST_MUL;
            ST_MUL:   n_state = ST_DIV;
            ST_DIV:   if (r_k == '0) n_state = ST_SETUP;
            ST_SETUP: n_state = w_early ? ST_IDLE : ST_WALK;
            ST_WALK:  if (w_last) n_state = ST_DRAIN;
            ST_DRAIN: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // memory write side
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_rd_addr;
        w_wdata = w_rdata;
        priority if (r_state == ST_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr;
            w_wdata = '0;
        end else if (r_rd_vld && (r_req == REQ_ADD)) begin
            w_we    = 1'b1;
            w_wdata = w_rdata | w_bit;
        end else if (r_rd_vld && (r_req == REQ_REMOVE)) begin
            w_we    = 1'b1;
            w_wdata = w_rdata & ~w_bit;
        end
    end

    ugsi_ram #(
        .WIDTH (ME),
        .DEPTH (DEPTH)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr      <= '0;
            r_done     <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_grid_div <= GRID_DIV_RST;
            r_scene_w  <= SCENE_RST;
            r_scene_h  <= SCENE_RST;
        end else begin
            r_state  <= n_state;
            r_done   <= (r_state == ST_DRAIN) || ((r_state == ST_SETUP) && w_early);
            r_rd_vld <= (r_state == ST_WALK);
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_GRID_DIV: r_grid_div <= i_cfg_wdata[DIV_W-1:0];
                    CFG_SCENE_W:  r_scene_w  <= i_cfg_wdata[SCENE_W-1:0];
                    CFG_SCENE_H:  r_scene_h  <= i_cfg_wdata[SCENE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_req      <= i_req_type;
                r_id       <= i_entity_id;
                r_coord[0] <= i_box_x_min;
                r_coord[1] <= i_box_y_min;
                r_coord[2] <= i_box_x_max;
                r_coord[3] <= i_box_y_max;
            end
            ST_MUL: begin
                // scaled coordinate (2c + s) * d and the bound 2s * d per axis
                for (int i = 0; i < 4; i++) begin
                    logic [SCENE_W-1:0] s;
                    logic signed [PW-1:0] sum;
                    s   = (i % 2 == 0) ? w_sw : w_sh;
                    sum = ($signed(PW'(r_coord[i])) <<< 1) + $signed({{(PW-SW_PAD){1'b0}}, s});
                    r_num[i] <= NW'($signed(NW'(sum)) * $signed({{(NW-DW){1'b0}}, w_d}));
                    r_rem[i] <= NW'($signed(NW'(sum)) * $signed({{(NW-DW){1'b0}}, w_d}));
                    r_q[i]   <= '0;
                end
                r_s2[0]  <= {w_sw, 1'b0};
                r_s2[1]  <= {w_sh, 1'b0};
                r_lim[0] <= LW'({w_sw, 1'b0}) * LW'(w_d);
                r_lim[1] <= LW'({w_sh, 1'b0}) * LW'(w_d);
                r_k      <= KW'(QW - 1);
            end
            ST_DIV: begin
                // restoring division, one quotient bit per cycle on all four lanes
                for (int i = 0; i < 4; i++) begin
                    logic [NW-1:0] dvs;
                    dvs = NW'(r_s2[i % 2]) << r_k;
                    if (r_rem[i] >= dvs) begin
                        r_rem[i] <= r_rem[i] - dvs;
                        r_q[i]   <= r_q[i] | (QW'(1) << r_k);
                    end
                end
                r_k <= r_k - KW'(1);
            end
            ST_SETUP: begin
                r_x0  <= w_cell[0];
                r_x1  <= w_cell[2];
                r_y1  <= w_cell[3];
                r_cx  <= w_cell[0];
                r_cy  <= w_cell[1];
                r_cnt <= '0;
                r_acc <= '0;
                if (w_early) begin
                    r_mask  <= '0;
                    r_count <= '0;
                end
            end
            ST_WALK: begin
                r_rd_addr <= w_raddr;
                r_cnt     <= r_cnt + CNT_W'(1);
                if (r_cx == r_x1) begin
                    r_cx <= r_x0;
                    r_cy <= r_cy + QW'(1);
                end else begin
                    r_cx <= r_cx + QW'(1);
                end
            end
            ST_DRAIN: begin
                r_count <= r_cnt;
                if (r_req == REQ_QUERY) begin
                    r_mask <= MASK_W'((r_acc | w_rdata) & ~w_bit);
                end else begin
                    r_mask <= '0;
                end
            end
            default: ;
        endcase
        if (r_rd_vld && (r_state == ST_WALK)) begin
            r_acc <= r_acc | w_rdata;
        end
    end

    assign o_done           = r_done;
    assign o_neighbour_mask = r_mask;
    assign o_cells_covered  = r_count;

    // a write-back never lands on the cell being read in the same cycle
    a_no_rmw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK && w_we) |-> (w_raddr != w_waddr))
        else $error("read-modify-write overlap on one cell");

    // the walk stays inside the covered rectangle
    a_walk_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_cx <= r_x1 && r_cy <= r_y1 && r_cx >= r_x0))
        else $error("cell walk left the box");

    // a result follows only the drain cycle or an early exit
    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(r_state) == ST_DRAIN || $past(r_state) == ST_SETUP))
        else $error("result strobe without a finished request");

    // only a query reports neighbours
    a_mask_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_neighbour_mask != '0) |-> (r_req == REQ_QUERY))
        else $error("neighbour mask on a non-query request");

endmodule

`default_nettype wire

// ===== rtl/ugsi_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ugsi_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
